[rtl/core/fpsp_pkg.sv]
// Shared constants, types and helper functions for the fisheye pixel-to-sphere unit.
// Used by fpsp_cordic, fpsp_div and fisheye_pixel_to_sphere_point_unit; no dependencies.
package fpsp_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int MAX_STEPS = 24;

  // datapath widths
  localparam int PW = 18;          // centered pixel coordinate, Q.4 signed
  localparam int SW = 43;          // square root work width
  localparam int SQ_STEPS = 21;    // root bits
  localparam int RW = 21;          // radius r8, Q.8
  localparam int AW = 32;          // angle per pixel, Q3.29
  localparam int XW = 36;          // CORDIC x/y
  localparam int ZW = 36;          // CORDIC angle
  localparam int MW = 60;          // radius times CORDIC magnitude
  localparam int TW = 31;          // scaled sin/cos, Q.16 signed
  localparam int NW = 53;          // dividend
  localparam int QW = 30;          // quotient bits
  localparam int OW = 25;          // result field width
  localparam int DIV_BITS = 32;    // angle-per-pixel divider steps
  localparam int CW = 6;           // divider step counter

  localparam int IMG_W = 13;
  localparam int FOV_W = 16;
  localparam int RAD_W = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOV    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd3;

  localparam logic [IMG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [IMG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [FOV_W-1:0] FOV_RESET    = 16'd25736;
  localparam logic [RAD_W-1:0] RADIUS_RESET = 24'd65536;

  localparam logic [IMG_W-1:0] MIN_RESET =
    (WIDTH_RESET < HEIGHT_RESET) ? WIDTH_RESET : HEIGHT_RESET;
  localparam logic [AW-1:0] APP_RESET =
    AW'((64'(FOV_RESET) << 16) / 64'(MIN_RESET));

  localparam logic [AW-1:0] PI_Q29      = 32'd1686629713;
  localparam logic [AW-1:0] HALF_PI_Q29 = 32'd843314857;

  localparam logic signed [63:0] OUT_MAX = 64'sd16777215;
  localparam logic signed [63:0] OUT_MIN = -64'sd16777216;

  localparam logic [31:0] ATAN_Q29 [0:MAX_STEPS-1] = '{
    32'd421657428, 32'd248918915, 32'd131521918, 32'd66762579, 32'd33510843,
    32'd16771758,  32'd8387925,   32'd4194219,   32'd2097141,  32'd1048575,
    32'd524288,    32'd262144,    32'd131072,    32'd65536,    32'd32768,
    32'd16384,     32'd8192,      32'd4096,      32'd2048,     32'd1024,
    32'd512,       32'd256,       32'd128,       32'd64
  };

  // square root of the squared CORDIC gain, Q.30, evaluated at elaboration
  function automatic logic [63:0] gain_root(input int n);
    logic [63:0] g2;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    g2 = 64'd1 << 30;
    for (int i = 0; i < n; i++) g2 = g2 + (g2 >> (2 * i));
    v = g2 << 30;
    r = '0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  localparam logic [63:0] CORDIC_K = (64'd1 << 60) / gain_root(CORDIC_ITERATIONS);

  typedef struct packed {
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic [RW-1:0]        r8;
    logic                 oov;
    logic                 neg_cos;
  } fpsp_side_t;

  typedef struct packed {
    logic                 zero;
    logic                 oov;
    logic signed [OW-1:0] pz;
  } fpsp_tail_t;

  function automatic logic signed [OW-1:0] sat_out(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = v;
    if (v > OUT_MAX) c = OUT_MAX;
    if (v < OUT_MIN) c = OUT_MIN;
    return c[OW-1:0];
  endfunction

endpackage

[rtl/core/fpsp_cordic.sv]
// Rotation-mode CORDIC, one registered stage per iteration, giving cos and sin in Q6.30.
// Depends on fpsp_pkg (widths, arctangent table, gain compensation, side-band type).
module fpsp_cordic (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [fpsp_pkg::ZW-1:0]    z_i,
  input  fpsp_pkg::fpsp_side_t              side_i,
  output logic                              valid_o,
  output logic signed [fpsp_pkg::XW-1:0]    x_o,
  output logic signed [fpsp_pkg::XW-1:0]    y_o,
  output fpsp_pkg::fpsp_side_t              side_o
);
  import fpsp_pkg::*;

  localparam int N = CORDIC_ITERATIONS;

  logic              vld_q  [N];
  logic signed [XW-1:0] x_q [N];
  logic signed [XW-1:0] y_q [N];
  logic signed [ZW-1:0] z_q [N];
  fpsp_side_t        side_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic              vi;
    logic signed [XW-1:0] xi, yi, xs, ys;
    logic signed [ZW-1:0] zi, at;
    fpsp_side_t        si;

    if (i == 0) begin : g_head
      assign vi = valid_i;
      assign xi = XW'(CORDIC_K);
      assign yi = '0;
      assign zi = z_i;
      assign si = side_i;
    end else begin : g_body
      assign vi = vld_q[i-1];
      assign xi = x_q[i-1];
      assign yi = y_q[i-1];
      assign zi = z_q[i-1];
      assign si = side_q[i-1];
    end

    assign at = ZW'(ATAN_Q29[i]);
    assign xs = xi >>> i;
    assign ys = yi >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vi;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[i] <= si;
      if (zi >= 0) begin
        x_q[i] <= xi - ys;
        y_q[i] <= yi + xs;
        z_q[i] <= zi - at;
      end else begin
        x_q[i] <= xi + ys;
        y_q[i] <= yi - xs;
        z_q[i] <= zi + at;
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign x_o     = x_q[N-1];
  assign y_o     = y_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

[rtl/core/fpsp_div.sv]
// Two-lane pipelined restoring divider, one quotient bit per stage, truncating toward zero.
// Depends on fpsp_pkg (widths and the tail side-band type).
module fpsp_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [fpsp_pkg::NW-1:0]    num_x_i,
  input  logic signed [fpsp_pkg::NW-1:0]    num_y_i,
  input  logic [fpsp_pkg::RW-1:0]           den_i,
  input  fpsp_pkg::fpsp_tail_t              tail_i,
  output logic                              valid_o,
  output logic signed [fpsp_pkg::QW:0]      q_x_o,
  output logic signed [fpsp_pkg::QW:0]      q_y_o,
  output fpsp_pkg::fpsp_tail_t              tail_o
);
  import fpsp_pkg::*;

  logic             vld_q  [QW];
  logic [RW-1:0]    remx_q [QW];
  logic [RW-1:0]    remy_q [QW];
  logic [QW-1:0]    wx_q   [QW];
  logic [QW-1:0]    wy_q   [QW];
  logic             negx_q [QW];
  logic             negy_q [QW];
  logic [RW-1:0]    den_q  [QW];
  fpsp_tail_t       tail_q [QW];

  logic [NW-1:0] magx, magy;
  assign magx = num_x_i[NW-1] ? NW'(-num_x_i) : NW'(num_x_i);
  assign magy = num_y_i[NW-1] ? NW'(-num_y_i) : NW'(num_y_i);

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic          vi, nxi, nyi, gex, gey;
    logic [RW-1:0] rxi, ryi, di;
    logic [QW-1:0] wxi, wyi;
    logic [RW:0]   rx2, ry2;
    fpsp_tail_t    ti;

    if (j == 0) begin : g_head
      // the quotient fits QW bits, so the top of the dividend is already below den
      assign vi  = valid_i;
      assign rxi = magx[QW +: RW];
      assign ryi = magy[QW +: RW];
      assign wxi = magx[QW-1:0];
      assign wyi = magy[QW-1:0];
      assign nxi = num_x_i[NW-1];
      assign nyi = num_y_i[NW-1];
      assign di  = den_i;
      assign ti  = tail_i;
    end else begin : g_body
      assign vi  = vld_q[j-1];
      assign rxi = remx_q[j-1];
      assign ryi = remy_q[j-1];
      assign wxi = wx_q[j-1];
      assign wyi = wy_q[j-1];
      assign nxi = negx_q[j-1];
      assign nyi = negy_q[j-1];
      assign di  = den_q[j-1];
      assign ti  = tail_q[j-1];
    end

    assign rx2 = {rxi, wxi[QW-1]};
    assign ry2 = {ryi, wyi[QW-1]};
    assign gex = rx2 >= {1'b0, di};
    assign gey = ry2 >= {1'b0, di};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= vi;
      end
    end

    always_ff @(posedge clk_i) begin
      remx_q[j] <= gex ? RW'(rx2 - {1'b0, di}) : RW'(rx2);
      remy_q[j] <= gey ? RW'(ry2 - {1'b0, di}) : RW'(ry2);
      // shift dividend bits out the top, quotient bits in the bottom
      wx_q[j]   <= {wxi[QW-2:0], gex};
      wy_q[j]   <= {wyi[QW-2:0], gey};
      negx_q[j] <= nxi;
      negy_q[j] <= nyi;
      den_q[j]  <= di;
      tail_q[j] <= ti;
    end
  end

  logic signed [QW:0] qx_pos, qy_pos;
  assign qx_pos  = $signed({1'b0, wx_q[QW-1]});
  assign qy_pos  = $signed({1'b0, wy_q[QW-1]});
  assign q_x_o   = negx_q[QW-1] ? -qx_pos : qx_pos;
  assign q_y_o   = negy_q[QW-1] ? -qy_pos : qy_pos;
  assign valid_o = vld_q[QW-1];
  assign tail_o  = tail_q[QW-1];

endmodule

[rtl/core/fisheye_pixel_to_sphere_point_unit.sv]
// Top level: equidistant fisheye unprojection of one pixel to a point on a sphere.
// Depends on fpsp_pkg, fpsp_cordic and fpsp_div.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+-----------------------------------------------
//  pixel in  | start_i, busy_o          | pixel_x_i, pixel_y_i
//  point out | done_o (strobe)          | point_x_o, point_y_o, point_z_o, out_of_view_o
//  config    | cfg_valid_i, cfg_ready_o | cfg_index_i, cfg_data_i
//
// One pixel per clock while busy_o is low; each result passes through the 21 root
// stages, the CORDIC stages and the divider. A config write keeps busy_o high while
// the serial divider rebuilds the angle per pixel. Reset clears the pipeline and
// loads the reset register values.
// done_o cannot be held off: the pipeline never stalls.
module fisheye_pixel_to_sphere_point_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [15:0]                          pixel_x_i,
  input  logic [15:0]                          pixel_y_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [fpsp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [fpsp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                 done_o,
  output logic signed [fpsp_pkg::OW-1:0]       point_x_o,
  output logic signed [fpsp_pkg::OW-1:0]       point_y_o,
  output logic signed [fpsp_pkg::OW-1:0]       point_z_o,
  output logic                                 out_of_view_o
);
  import fpsp_pkg::*;

  localparam int LAT = 29 + CORDIC_ITERATIONS + QW;

  // ---------------- configuration and angle-per-pixel divider ----------------
  logic [IMG_W-1:0] width_q, height_q, min_dim, den_cfg;
  logic [FOV_W-1:0] fov_q;
  logic [RAD_W-1:0] radius_q;
  logic [AW-1:0]    app_q, app_d, dnum_q, dnum_d;
  logic [IMG_W-1:0] drem_q, drem_d, dden_q, dden_d;
  logic [IMG_W:0]   drem2;
  logic             dge;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             pend_q;
  logic             cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;
  assign busy_o      = pend_q | (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      fov_q    <= FOV_RESET;
      radius_q <= RADIUS_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        CFG_WIDTH:  width_q  <= cfg_data_i[IMG_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[IMG_W-1:0];
        CFG_FOV:    fov_q    <= cfg_data_i[FOV_W-1:0];
        CFG_RADIUS: radius_q <= cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign min_dim = (width_q < height_q) ? width_q : height_q;
  assign den_cfg = (min_dim == '0) ? IMG_W'(1) : min_dim;
  assign drem2   = {drem_q, dnum_q[AW-1]};
  assign dge     = drem2 >= {1'b0, dden_q};

  always_comb begin
    app_d  = app_q;
    dnum_d = dnum_q;
    drem_d = drem_q;
    dden_d = dden_q;
    cnt_d  = cnt_q;
    if (pend_q) begin
      // restart from the registers as they stand now
      dnum_d = {fov_q, 16'd0};
      drem_d = '0;
      dden_d = den_cfg;
      cnt_d  = CW'(DIV_BITS);
    end else if (cnt_q != '0) begin
      drem_d = dge ? IMG_W'(drem2 - {1'b0, dden_q}) : IMG_W'(drem2);
      dnum_d = {dnum_q[AW-2:0], dge};
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) app_d = {dnum_q[AW-2:0], dge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      app_q  <= APP_RESET;
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      app_q  <= app_d;
      cnt_q  <= cnt_d;
      pend_q <= cfg_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    dnum_q <= dnum_d;
    drem_q <= drem_d;
    dden_q <= dden_d;
  end

  // ---------------- stage A: center the pixel ----------------
  logic                 a_vld_q;
  logic signed [PW-1:0] a_px_q, a_py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else         a_vld_q <= start_i & ~busy_o;
  end

  always_ff @(posedge clk_i) begin
    a_px_q <= $signed({2'b0, pixel_x_i}) - $signed({2'b0, width_q, 3'b0});
    a_py_q <= $signed({2'b0, height_q, 3'b0}) - $signed({2'b0, pixel_y_i});
  end

  // ---------------- stage B: squared distance ----------------
  logic                   b_vld_q;
  logic [33:0]            b_sum_q;
  logic signed [PW-1:0]   b_px_q, b_py_q;
  logic signed [2*PW-1:0] sqx, sqy;

  assign sqx = a_px_q * a_px_q;
  assign sqy = a_py_q * a_py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_vld_q <= 1'b0;
    else         b_vld_q <= a_vld_q;
  end

  always_ff @(posedge clk_i) begin
    b_sum_q <= 34'($unsigned(sqx)) + 34'($unsigned(sqy));
    b_px_q  <= a_px_q;
    b_py_q  <= a_py_q;
  end

  // ---------------- square root, one root bit per stage ----------------
  logic                 sq_vld_q [SQ_STEPS];
  logic [SW-1:0]        sq_v_q   [SQ_STEPS];
  logic [SW-1:0]        sq_r_q   [SQ_STEPS];
  logic signed [PW-1:0] sq_px_q  [SQ_STEPS];
  logic signed [PW-1:0] sq_py_q  [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic                 vi;
    logic [SW-1:0]        v_in, r_in, bit_k, trial;
    logic signed [PW-1:0] pxi, pyi;

    if (k == 0) begin : g_head
      assign vi   = b_vld_q;
      assign v_in = {1'b0, b_sum_q, 8'd0};
      assign r_in = '0;
      assign pxi  = b_px_q;
      assign pyi  = b_py_q;
    end else begin : g_body
      assign vi   = sq_vld_q[k-1];
      assign v_in = sq_v_q[k-1];
      assign r_in = sq_r_q[k-1];
      assign pxi  = sq_px_q[k-1];
      assign pyi  = sq_py_q[k-1];
    end

    assign bit_k = SW'(1) << (2 * (SQ_STEPS - 1 - k));
    assign trial = r_in + bit_k;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sq_vld_q[k] <= 1'b0;
      else         sq_vld_q[k] <= vi;
    end

    always_ff @(posedge clk_i) begin
      if (v_in >= trial) begin
        sq_v_q[k] <= v_in - trial;
        sq_r_q[k] <= (r_in >> 1) + bit_k;
      end else begin
        sq_v_q[k] <= v_in;
        sq_r_q[k] <= r_in >> 1;
      end
      sq_px_q[k] <= pxi;
      sq_py_q[k] <= pyi;
    end
  end

  // ---------------- stage P1: latitude product ----------------
  logic                 p_vld_q;
  logic [RW+AW-1:0]     p_prod_q;
  logic [RW-1:0]        p_r8_q;
  logic signed [PW-1:0] p_px_q, p_py_q;
  logic [RW-1:0]        r8;

  assign r8 = sq_r_q[SQ_STEPS-1][RW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p_vld_q <= 1'b0;
    else         p_vld_q <= sq_vld_q[SQ_STEPS-1];
  end

  always_ff @(posedge clk_i) begin
    p_prod_q <= r8 * app_q;
    p_r8_q   <= r8;
    p_px_q   <= sq_px_q[SQ_STEPS-1];
    p_py_q   <= sq_py_q[SQ_STEPS-1];
  end

  // ---------------- stage H: view test and quadrant fold ----------------
  logic                 h_vld_q;
  logic signed [ZW-1:0] h_z_q;
  fpsp_side_t           h_side_q;
  logic [AW-1:0]        theta;
  logic                 fold;

  assign theta = p_prod_q[AW+7:8];
  assign fold  = theta > HALF_PI_Q29;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) h_vld_q <= 1'b0;
    else         h_vld_q <= p_vld_q;
  end

  always_ff @(posedge clk_i) begin
    h_z_q            <= fold ? ZW'(PI_Q29) - ZW'(theta) : ZW'(theta);
    h_side_q.px      <= p_px_q;
    h_side_q.py      <= p_py_q;
    h_side_q.r8      <= p_r8_q;
    h_side_q.oov     <= p_prod_q > ((RW + AW)'(fov_q) << 23);
    h_side_q.neg_cos <= fold;
  end

  // ---------------- CORDIC ----------------
  logic                 c_vld;
  logic signed [XW-1:0] c_x, c_y;
  fpsp_side_t           c_side;

  fpsp_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (h_vld_q),
    .z_i     (h_z_q),
    .side_i  (h_side_q),
    .valid_o (c_vld),
    .x_o     (c_x),
    .y_o     (c_y),
    .side_o  (c_side)
  );

  // ---------------- stage M1: scale by radius ----------------
  logic                 m_vld_q, m_sx_q, m_sy_q;
  logic [MW-1:0]        m_px_q, m_py_q;
  fpsp_side_t           m_side_q;
  logic [XW-1:0]        magx, magy;

  assign magx = c_x[XW-1] ? XW'(-c_x) : XW'(c_x);
  assign magy = c_y[XW-1] ? XW'(-c_y) : XW'(c_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_vld_q <= 1'b0;
    else         m_vld_q <= c_vld;
  end

  always_ff @(posedge clk_i) begin
    m_px_q   <= radius_q * magx;
    m_py_q   <= radius_q * magy;
    m_sx_q   <= c_x[XW-1] ^ c_side.neg_cos;
    m_sy_q   <= c_y[XW-1];
    m_side_q <= c_side;
  end

  // ---------------- stage M2: sign and saturate z ----------------
  logic                 n_vld_q;
  logic signed [TW-1:0] n_t_q;
  logic signed [OW-1:0] n_pz_q;
  fpsp_side_t           n_side_q;
  logic signed [TW-1:0] tz_pos, ty_pos, pz_full;

  assign tz_pos  = $signed({1'b0, m_px_q[MW-1:30]});
  assign ty_pos  = $signed({1'b0, m_py_q[MW-1:30]});
  assign pz_full = m_sx_q ? -tz_pos : tz_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) n_vld_q <= 1'b0;
    else         n_vld_q <= m_vld_q;
  end

  always_ff @(posedge clk_i) begin
    n_t_q    <= m_sy_q ? -ty_pos : ty_pos;
    n_pz_q   <= sat_out(64'(pz_full));
    n_side_q <= m_side_q;
  end

  // ---------------- stage P2: numerators ----------------
  logic                 q_vld_q;
  logic signed [NW-1:0] q_nx_q, q_ny_q;
  logic [RW-1:0]        q_den_q;
  fpsp_tail_t           q_tail_q;
  logic signed [PW+3:0] px16, py16;

  assign px16 = {n_side_q.px, 4'd0};
  assign py16 = {n_side_q.py, 4'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) q_vld_q <= 1'b0;
    else         q_vld_q <= n_vld_q;
  end

  always_ff @(posedge clk_i) begin
    q_nx_q        <= NW'(n_t_q) * NW'(px16);
    q_ny_q        <= NW'(n_t_q) * NW'(py16);
    q_den_q       <= n_side_q.r8;
    q_tail_q.zero <= n_side_q.r8 == '0;
    q_tail_q.oov  <= n_side_q.oov;
    q_tail_q.pz   <= n_pz_q;
  end

  // ---------------- divide by radius in pixels ----------------
  logic               d_vld;
  logic signed [QW:0] d_qx, d_qy;
  fpsp_tail_t         d_tail;

  fpsp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_vld_q),
    .num_x_i (q_nx_q),
    .num_y_i (q_ny_q),
    .den_i   (q_den_q),
    .tail_i  (q_tail_q),
    .valid_o (d_vld),
    .q_x_o   (d_qx),
    .q_y_o   (d_qy),
    .tail_o  (d_tail)
  );

  // ---------------- output register ----------------
  logic done_q;
  logic signed [OW-1:0] pt_x_q, pt_y_q, pt_z_q;
  logic oov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= d_vld;
  end

  always_ff @(posedge clk_i) begin
    // drop x and y at the center or out of view
    pt_x_q <= (d_tail.zero | d_tail.oov) ? '0 : sat_out(64'(d_qx));
    pt_y_q <= (d_tail.zero | d_tail.oov) ? '0 : sat_out(-(64'(d_qy)));
    pt_z_q <= d_tail.oov ? '0 : d_tail.pz;
    oov_q  <= d_tail.oov;
  end

  assign done_o        = done_q;
  assign point_x_o     = pt_x_q;
  assign point_y_o     = pt_y_q;
  assign point_z_o     = pt_z_q;
  assign out_of_view_o = oov_q;

  // ---------------- assertions ----------------
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("result beat missing at fixed latency");

  a_oov_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_of_view_o) |-> (point_x_o == '0 && point_y_o == '0 && point_z_o == '0))
    else $error("out-of-view point not zero");

  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> busy_o)
    else $error("busy not raised after config write");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DIV_BITS))
    else $error("divider step count out of range");

endmodule
